// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the core. Clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_IMPLY(lbl, a, b) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (a) |-> (b)) else $error("implication check failed");
// next-cycle implication
`define AST_NEXT(lbl, a, b) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (a) |=> (b)) else $error("next-cycle check failed");
`endif

// ===== rtl/core/c8_pkg.sv =====
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, constants and tables of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int QDEPTH      = 2;

    localparam logic [1:0]  KIND_LOAD = 2'd0;
    localparam logic [1:0]  KIND_EXEC = 2'd1;
    localparam logic [1:0]  KIND_READ = 2'd2;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] MEM_LAST  = 12'hFFF;
    localparam logic [6:0]  FONT_LEN  = 7'd80;

    typedef enum logic [1:0] {
        CMD_LOAD, CMD_EXEC, CMD_READ, CMD_NOP
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_STACK = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  random_byte;
        logic [4:0]  row;
    } t_item;

    typedef struct packed {
        logic hold;   // back end is running its clearing pass
        logic pop;    // back end takes the queue head
    } t_ctrl;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [63:0] row_pixels;
        logic        collision;
        logic        waiting_key;
        t_status     status;
    } t_result;

    typedef enum logic [4:0] {
        B_CLEAR, B_IDLE, B_ROW, B_F0, B_F1, B_F2, B_F3, B_F4, B_EXEC, B_FLAG,
        B_DRD, B_DWR, B_DVF, B_CLS, B_BCD, B_STRD, B_STWR, B_LDRD, B_LDWR, B_RESP
    } t_bstate;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        unique case (idx)
            7'd0:  b = 8'hF0; 7'd1:  b = 8'h90; 7'd2:  b = 8'h90; 7'd3:  b = 8'h90;
            7'd4:  b = 8'hF0; 7'd5:  b = 8'h20; 7'd6:  b = 8'h60; 7'd7:  b = 8'h20;
            7'd8:  b = 8'h20; 7'd9:  b = 8'h70; 7'd10: b = 8'hF0; 7'd11: b = 8'h10;
            7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
            7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
            7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
            7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
            7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
            7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
            7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
            7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
            7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
            7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
            7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
            7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
            7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
            7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
            7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
            7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
            7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // decimal digits of an 8-bit value: {hundreds, tens, units}
    function automatic logic [23:0] bcd_digits(input logic [7:0] v);
        logic [7:0]  h;
        logic [7:0]  r;
        logic [14:0] p;
        logic [7:0]  t;
        logic [7:0]  u;
        h = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
        r = v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0));
        p = {8'd0, r[6:0]} * 15'd205;
        t = {4'd0, p[14:11]};
        u = r - {t[4:0], 3'd0} - {t[6:0], 1'b0};
        return {h, t, u};
    endfunction
endpackage

// ===== rtl/core/c8_front.sv =====
// ----------------------------------------------------------------------------
// c8_front
// Accepts items, classifies them by kind and queues them for the back end.
// ----------------------------------------------------------------------------
module c8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_kind,
    input  logic [11:0]      i_address,
    input  logic [7:0]       i_data,
    input  logic [15:0]      i_keys,
    input  logic [7:0]       i_random_byte,
    input  logic [4:0]       i_row,
    input  c8_pkg::t_ctrl    i_ctrl,
    output logic             o_q_valid,
    output c8_pkg::t_item    o_q_item
);
    import c8_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_item         r_q [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    t_item         cls;
    logic          push, pop;

    always_comb begin
        unique case (i_kind)
            KIND_LOAD: cls.cmd = CMD_LOAD;
            KIND_EXEC: cls.cmd = CMD_EXEC;
            KIND_READ: cls.cmd = CMD_READ;
            default:   cls.cmd = CMD_NOP;
        endcase
        cls.address     = i_address;
        cls.data        = i_data;
        cls.keys        = i_keys;
        cls.random_byte = i_random_byte;
        cls.row         = i_row;
    end

    assign o_ready   = (r_cnt != CW'(QDEPTH)) && !i_ctrl.hold;
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_ctrl.pop && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end
endmodule

// ===== rtl/core/c8_back.sv =====
// ----------------------------------------------------------------------------
// c8_back
// Sequencer that carries out queued items against memory, registers, display.
// ----------------------------------------------------------------------------
module c8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  c8_pkg::t_item    i_q_item,
    output c8_pkg::t_ctrl    o_ctrl,
    output logic             o_valid,
    input  logic             i_ready,
    output c8_pkg::t_result  o_res
);
    import c8_pkg::*;

    // storage
    logic [7:0]  r_mem [4096];
    logic [63:0] r_scr [32];
    logic [7:0]  r_v   [16];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [7:0]  mem_q, v_q;
    logic [63:0] scr_q;

    // ports
    logic        mem_we, scr_we, v_we, stk_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, v_wd;
    logic [4:0]  scr_wa, scr_ra;
    logic [63:0] scr_wd;
    logic [3:0]  v_wa, v_ra;

    t_bstate     r_state, n_state;
    t_item       r_item;
    logic [11:0] r_pc, n_pc, r_i, n_i, r_cnt, n_cnt;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [7:0]  r_dt, n_dt, r_snd, n_snd;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx, r_vy, n_vy, r_v0, n_v0, r_flag, n_flag;
    logic        r_coll, n_coll, r_wait, n_wait;
    t_status     r_stat, n_stat;
    logic [63:0] r_pix, n_pix;
    logic        r_ov, n_ov;
    t_result     r_res, n_res;

    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn, pc2, pc4;
    logic [8:0]  sum9;
    logic [63:0] mask;
    logic [23:0] bcd;
    logic [4:0]  drow;
    logic [3:0]  key_idx;
    logic        key_any;
    logic        resp_go;

    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_kk  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign pc2    = r_pc + 12'd2;
    assign pc4    = r_pc + 12'd4;
    assign sum9   = {1'b0, r_vx} + {1'b0, r_vy};
    assign mask   = 64'(({mem_q, 56'd0, mem_q, 56'd0}) >> r_vx[5:0]);
    assign bcd    = bcd_digits(r_vx);
    assign drow   = r_vy[4:0] + r_cnt[4:0];
    assign resp_go = !r_ov || i_ready;

    always_comb begin
        key_idx = 4'd0;
        key_any = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (r_item.keys[k]) begin
                key_idx = 4'(k);
                key_any = 1'b1;
            end
        end
    end

    assign o_ctrl.hold = (r_state == B_CLEAR);
    assign o_ctrl.pop  = (r_state == B_IDLE) && i_q_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: if (r_cnt == MEM_LAST) n_state = B_IDLE;
            B_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.cmd)
                        CMD_EXEC: n_state = B_F0;
                        CMD_READ: n_state = B_ROW;
                        default:  n_state = B_RESP;
                    endcase
                end
            end
            B_ROW: n_state = B_RESP;
            B_F0:  n_state = B_F1;
            B_F1:  n_state = B_F2;
            B_F2:  n_state = B_F3;
            B_F3:  n_state = B_F4;
            B_F4:  n_state = B_EXEC;
            B_EXEC: begin
                n_state = B_RESP;
                unique case (r_op[15:12])
                    4'h0: if (r_op == 16'h00E0) n_state = B_CLS;
                    4'h8: if (op_n == 4'h4 || op_n == 4'h5 || op_n == 4'h6 ||
                              op_n == 4'h7 || op_n == 4'hE) n_state = B_FLAG;
                    4'hD: n_state = (op_n == 4'd0) ? B_DVF : B_DRD;
                    4'hF: begin
                        if (op_kk == 8'h33) n_state = B_BCD;
                        if (op_kk == 8'h55) n_state = B_STRD;
                        if (op_kk == 8'h65) n_state = B_LDRD;
                    end
                    default: n_state = B_RESP;
                endcase
            end
            B_FLAG: n_state = B_RESP;
            B_DRD:  n_state = B_DWR;
            B_DWR:  n_state = (r_cnt[3:0] == op_n - 4'd1) ? B_DVF : B_DRD;
            B_DVF:  n_state = B_RESP;
            B_CLS:  if (r_cnt[4:0] == 5'd31) n_state = B_RESP;
            B_BCD:  if (r_cnt[1:0] == 2'd2) n_state = B_RESP;
            B_STRD: n_state = B_STWR;
            B_STWR: n_state = (r_cnt[3:0] == op_x) ? B_RESP : B_STRD;
            B_LDRD: n_state = B_LDWR;
            B_LDWR: n_state = (r_cnt[3:0] == op_x) ? B_RESP : B_LDRD;
            B_RESP: if (resp_go) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // datapath and storage ports
    always_comb begin
        n_pc = r_pc; n_i = r_i; n_cnt = r_cnt; n_sp = r_sp; n_dt = r_dt;
        n_snd = r_snd; n_op = r_op; n_vx = r_vx; n_vy = r_vy; n_v0 = r_v0;
        n_flag = r_flag; n_coll = r_coll; n_wait = r_wait; n_stat = r_stat;
        n_pix = r_pix; n_res = r_res;
        n_ov = r_ov && !i_ready;
        mem_we = 1'b0; mem_wa = r_i + r_cnt; mem_wd = 8'd0; mem_ra = r_pc;
        scr_we = 1'b0; scr_wa = r_cnt[4:0]; scr_wd = 64'd0; scr_ra = drow;
        v_we = 1'b0; v_wa = op_x; v_wd = 8'd0; v_ra = 4'd0;
        stk_we = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = (r_cnt >= FONT_BASE && r_cnt < FONT_BASE + 12'(FONT_LEN)) ?
                         font_byte(7'(r_cnt - FONT_BASE)) : 8'd0;
                scr_we = (r_cnt < 12'd32);
                v_we   = (r_cnt < 12'd16);
                v_wa   = r_cnt[3:0];
                n_cnt  = r_cnt + 12'd1;
            end
            B_IDLE: begin
                scr_ra = i_q_item.row;
                mem_ra = r_pc;
                n_op = 16'd0; n_pix = 64'd0; n_coll = 1'b0; n_wait = 1'b0;
                n_stat = ST_OK; n_cnt = 12'd0;
                if (i_q_valid && i_q_item.cmd == CMD_LOAD) begin
                    mem_we = 1'b1;
                    mem_wa = i_q_item.address;
                    mem_wd = i_q_item.data;
                end
            end
            B_ROW: n_pix = scr_q;
            B_F0: begin
                mem_ra = pc2 - 12'd1;
                n_op[15:8] = mem_q;
            end
            B_F1: begin
                n_op[7:0] = mem_q;
                v_ra = op_x;
            end
            B_F2: begin
                n_vx = v_q;
                v_ra = op_y;
            end
            B_F3: begin
                n_vy = v_q;
                v_ra = 4'd0;
            end
            B_F4: n_v0 = v_q;
            B_EXEC: begin
                n_pc = pc2;
                unique case (r_op[15:12])
                    4'h0: begin
                        if (r_op == 16'h00EE) begin
                            if (r_sp == '0 || r_sp > SP_W'(STACK_DEPTH)) begin
                                n_stat = ST_STACK;
                            end else begin
                                n_sp = r_sp - 1'b1;
                                n_pc = r_stack[STK_IDX_W'(r_sp - 1'b1)] + 12'd2;
                            end
                        end else if (r_op != 16'h00E0) begin
                            n_stat = ST_UNSUP;
                        end
                    end
                    4'h1: n_pc = op_nnn;
                    4'h2: begin
                        if (r_sp >= SP_W'(STACK_DEPTH)) begin
                            n_stat = ST_STACK;
                        end else begin
                            stk_we = 1'b1;
                            n_sp = r_sp + 1'b1;
                            n_pc = op_nnn;
                        end
                    end
                    4'h3: if (r_vx == op_kk) n_pc = pc4;
                    4'h4: if (r_vx != op_kk) n_pc = pc4;
                    4'h5: if (r_vx == r_vy) n_pc = pc4;
                    4'h6: begin v_we = 1'b1; v_wd = op_kk; end
                    4'h7: begin v_we = 1'b1; v_wd = r_vx + op_kk; end
                    4'h8: begin
                        v_we = 1'b1;
                        unique case (op_n)
                            4'h0: v_wd = r_vy;
                            4'h1: v_wd = r_vx | r_vy;
                            4'h2: v_wd = r_vx & r_vy;
                            4'h3: v_wd = r_vx ^ r_vy;
                            4'h4: begin v_wd = sum9[7:0]; n_flag = {7'd0, sum9[8]}; end
                            4'h5: begin
                                v_wd = r_vx - r_vy; n_flag = {7'd0, r_vx >= r_vy};
                            end
                            4'h6: begin v_wd = {1'b0, r_vx[7:1]}; n_flag = {7'd0, r_vx[0]}; end
                            4'h7: begin
                                v_wd = r_vy - r_vx; n_flag = {7'd0, r_vy >= r_vx};
                            end
                            4'hE: begin v_wd = {r_vx[6:0], 1'b0}; n_flag = {7'd0, r_vx[7]}; end
                            default: begin v_we = 1'b0; n_stat = ST_UNSUP; end
                        endcase
                    end
                    4'h9: if (r_vx != r_vy) n_pc = pc4;
                    4'hA: n_i = op_nnn;
                    4'hB: n_pc = op_nnn + {4'd0, r_v0};
                    4'hC: begin v_we = 1'b1; v_wd = r_item.random_byte & op_kk; end
                    4'hD: begin n_coll = 1'b0; n_cnt = 12'd0; end
                    4'hE: begin
                        if (op_kk == 8'h9E) begin
                            if (r_item.keys[r_vx[3:0]]) n_pc = pc4;
                        end else if (op_kk == 8'hA1) begin
                            if (!r_item.keys[r_vx[3:0]]) n_pc = pc4;
                        end else begin
                            n_stat = ST_UNSUP;
                        end
                    end
                    default: begin
                        unique case (op_kk)
                            8'h07: begin v_we = 1'b1; v_wd = r_dt; end
                            8'h0A: begin
                                if (key_any) begin
                                    v_we = 1'b1; v_wd = {4'd0, key_idx};
                                end else begin
                                    n_wait = 1'b1; n_pc = r_pc;
                                end
                            end
                            8'h15: n_dt = r_vx;
                            8'h18: n_snd = r_vx;
                            8'h1E: n_i = r_i + {4'd0, r_vx};
                            8'h29: n_i = FONT_BASE + {6'd0, r_vx[3:0], 2'd0}
                                         + {8'd0, r_vx[3:0]};
                            8'h33, 8'h55, 8'h65: n_cnt = 12'd0;
                            default: n_stat = ST_UNSUP;
                        endcase
                    end
                endcase
            end
            B_FLAG: begin v_we = 1'b1; v_wa = 4'hF; v_wd = r_flag; end
            B_DRD: mem_ra = r_i + r_cnt;
            B_DWR: begin
                scr_we = 1'b1;
                scr_wa = drow;
                scr_wd = scr_q ^ mask;
                if ((scr_q & mask) != 64'd0) n_coll = 1'b1;
                n_cnt = r_cnt + 12'd1;
            end
            B_DVF: begin v_we = 1'b1; v_wa = 4'hF; v_wd = {7'd0, r_coll}; end
            B_CLS: begin
                scr_we = 1'b1;
                n_cnt = r_cnt + 12'd1;
            end
            B_BCD: begin
                mem_we = 1'b1;
                unique case (r_cnt[1:0])
                    2'd0:    mem_wd = bcd[23:16];
                    2'd1:    mem_wd = bcd[15:8];
                    default: mem_wd = bcd[7:0];
                endcase
                n_cnt = r_cnt + 12'd1;
            end
            B_STRD: v_ra = r_cnt[3:0];
            B_STWR: begin
                mem_we = 1'b1; mem_wd = v_q;
                n_cnt = r_cnt + 12'd1;
            end
            B_LDRD: mem_ra = r_i + r_cnt;
            B_LDWR: begin
                v_we = 1'b1; v_wa = r_cnt[3:0]; v_wd = mem_q;
                n_cnt = r_cnt + 12'd1;
            end
            B_RESP: begin
                if (resp_go) begin
                    n_ov = 1'b1;
                    n_res.pc = r_pc;
                    n_res.opcode = r_op;
                    n_res.row_pixels = r_pix;
                    n_res.collision = r_coll && (r_op[15:12] == 4'hD);
                    n_res.waiting_key = r_wait;
                    n_res.status = r_stat;
                end
            end
            default: ;
        endcase
    end

    // memories, registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) r_scr[scr_wa] <= scr_wd;
        scr_q <= r_scr[scr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_v[v_wa] <= v_wd;
        v_q <= r_v[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stack[STK_IDX_W'(r_sp)] <= r_pc;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ctrl.pop) r_item <= i_q_item;
        r_op <= n_op; r_vx <= n_vx; r_vy <= n_vy; r_v0 <= n_v0;
        r_flag <= n_flag; r_pix <= n_pix; r_res <= n_res;
        r_coll <= n_coll; r_wait <= n_wait; r_stat <= n_stat;
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_cnt   <= 12'd0;
            r_pc    <= PROG_START;
            r_i     <= 12'd0;
            r_sp    <= '0;
            r_dt    <= 8'd0;
            r_snd   <= 8'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_sp    <= n_sp;
            r_dt    <= n_dt;
            r_snd   <= n_snd;
            r_ov    <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
endmodule

// ===== rtl/core/chip8_instruction_core.sv =====
// Sequence: a load writes memory from idle; a row read passes B_ROW; an execute fetches the opcode
// and operands (B_F0-B_F4), runs B_EXEC, then the op's work: ALU flag, draw read/write per sprite row
// plus VF, FX55/FX65 per register, FX33 per digit, 00E0 per display row; every item ends in B_RESP.
// Throughput: one item at a time through the back-end sequencer; a 2-entry queue takes items while the
// back end or output stalls, until full. Reset: synchronous active low; a clearing pass over all of memory
// loads the font and zeroes memory, display and V registers, during which no item is accepted.
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 interpreter core: front queue plus execution sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module chip8_instruction_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item in
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    input  logic [4:0]  i_row,
    // result out
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_pc,
    output logic [15:0] o_opcode,
    output logic [63:0] o_row_pixels,
    output logic        o_collision,
    output logic        o_waiting_key,
    output logic [1:0]  o_status
);
    import c8_pkg::*;

    t_ctrl   ctrl;      // back end -> front: pop and clearing hold
    logic    q_valid;
    t_item   q_item;
    t_result res;

    // front: classify kind, buffer items
    c8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_keys        (i_keys),
        .i_random_byte (i_random_byte),
        .i_row         (i_row),
        .i_ctrl        (ctrl),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item)
    );

    // back: fetch, decode, execute, respond
    c8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_ctrl    (ctrl),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (res)
    );

    assign o_pc          = res.pc;
    assign o_opcode      = res.opcode;
    assign o_row_pixels  = res.row_pixels;
    assign o_collision   = res.collision;
    assign o_waiting_key = res.waiting_key;
    assign o_status      = res.status;

    // no item taken while the clearing pass runs
    `AST_IMPLY(a_no_accept_in_clear, ctrl.hold, !o_ready)
    // a key wait never comes with a fault
    `AST_IMPLY(a_wait_ok, o_valid && o_waiting_key, o_status == ST_OK)
    // stack faults only come from call or return
    `AST_IMPLY(a_stack_src, o_valid && o_status == ST_STACK, o_opcode[15:12] == 4'h0 || o_opcode[15:12] == 4'h2)
    // a popped item is never lost: the sequencer leaves idle after a pop
    `AST_NEXT(a_pop_leaves_idle, ctrl.pop, !ctrl.pop)
endmodule
